@@ rtl/core/ghrb_pkg.sv @@
// Shared types, constants, arctangent table and sequencer program of the navigator.
package ghrb_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int MAX_STEPS    = 40;
  localparam int STEPS        = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int CNT_W        = $clog2(STEPS);
  localparam int PC_W         = 6;

  localparam logic signed [33:0] DEG_TO_BAM = 34'sd320255973;
  localparam logic signed [33:0] RANGE_MUL  = 34'sd312823969;
  localparam logic signed [52:0] CORDIC_GAIN_Q30 = 53'sd652032874;
  localparam logic [34:0]        RANGE_MAX  = 35'd20020706000;

  localparam logic signed [30:0] TGT_LAT_RST = 31'sd459448010;
  localparam logic signed [31:0] TGT_LON_RST = -32'sd666422750;

  // configuration register indexes
  localparam logic REG_TARGET_LAT = 1'b0;
  localparam logic REG_TARGET_LON = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP, OP_CAPTURE, OP_VEC_HEAD, OP_VEC_GOAL, OP_VEC_RANGE, OP_ROT_HALF,
    OP_ROT_FULL, OP_CORDIC, OP_MUL_LO, OP_MUL_HI, OP_STORE, OP_SQRT_H,
    OP_SQRT_R, OP_SQRT, OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    M_NONE, M_DLAT, M_DLON, M_LAT, M_TLAT, M_S1, M_S2, M_CL, M_CB, M_QQ, M_RNG
  } msel_e;

  typedef enum logic [3:0] {
    D_NONE, D_HEAD, D_GOAL, D_S1, D_S2, D_CL1, D_CL2, D_A, D_B, D_C, D_H,
    D_Q, D_R, D_ANG, D_RNG
  } dst_e;

  typedef enum logic {CS_IDLE, CS_RUN} ctl_state_e;

  typedef struct packed {
    op_e   op;
    msel_e msel;
    dst_e  dst;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic sqrt_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] atan_tab(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'd536870912;
      6'd1:  v = 32'd316933406;
      6'd2:  v = 32'd167458907;
      6'd3:  v = 32'd85004756;
      6'd4:  v = 32'd42667331;
      6'd5:  v = 32'd21354465;
      6'd6:  v = 32'd10680862;
      6'd7:  v = 32'd5340245;
      6'd8:  v = 32'd2670163;
      6'd9:  v = 32'd1335087;
      6'd10: v = 32'd667544;
      6'd11: v = 32'd333772;
      6'd12: v = 32'd166886;
      6'd13: v = 32'd83443;
      6'd14: v = 32'd41722;
      6'd15: v = 32'd20861;
      6'd16: v = 32'd10430;
      6'd17: v = 32'd5215;
      6'd18: v = 32'd2608;
      6'd19: v = 32'd1304;
      6'd20: v = 32'd652;
      6'd21: v = 32'd326;
      6'd22: v = 32'd163;
      6'd23: v = 32'd81;
      6'd24: v = 32'd41;
      6'd25: v = 32'd20;
      6'd26: v = 32'd10;
      6'd27: v = 32'd5;
      6'd28: v = 32'd3;
      6'd29: v = 32'd1;
      6'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Sequencer program: one command per entry, iterative commands repeat until done.
  function automatic dp_cmd_t ucode(input logic [PC_W-1:0] pc);
    dp_cmd_t c;
    case (pc)
      6'd0:  c = '{OP_VEC_HEAD,  M_NONE, D_NONE};
      6'd1:  c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd2:  c = '{OP_STORE,     M_NONE, D_HEAD};
      6'd3:  c = '{OP_VEC_GOAL,  M_NONE, D_NONE};
      6'd4:  c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd5:  c = '{OP_STORE,     M_NONE, D_GOAL};
      6'd6:  c = '{OP_MUL_LO,    M_DLAT, D_NONE};
      6'd7:  c = '{OP_MUL_HI,    M_DLAT, D_NONE};
      6'd8:  c = '{OP_ROT_HALF,  M_NONE, D_NONE};
      6'd9:  c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd10: c = '{OP_STORE,     M_NONE, D_S1};
      6'd11: c = '{OP_MUL_LO,    M_DLON, D_NONE};
      6'd12: c = '{OP_MUL_HI,    M_DLON, D_NONE};
      6'd13: c = '{OP_ROT_HALF,  M_NONE, D_NONE};
      6'd14: c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd15: c = '{OP_STORE,     M_NONE, D_S2};
      6'd16: c = '{OP_MUL_LO,    M_LAT,  D_NONE};
      6'd17: c = '{OP_MUL_HI,    M_LAT,  D_NONE};
      6'd18: c = '{OP_ROT_FULL,  M_NONE, D_NONE};
      6'd19: c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd20: c = '{OP_STORE,     M_NONE, D_CL1};
      6'd21: c = '{OP_MUL_LO,    M_TLAT, D_NONE};
      6'd22: c = '{OP_MUL_HI,    M_TLAT, D_NONE};
      6'd23: c = '{OP_ROT_FULL,  M_NONE, D_NONE};
      6'd24: c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd25: c = '{OP_STORE,     M_NONE, D_CL2};
      6'd26: c = '{OP_MUL_LO,    M_S1,   D_NONE};
      6'd27: c = '{OP_MUL_HI,    M_S1,   D_NONE};
      6'd28: c = '{OP_STORE,     M_NONE, D_A};
      6'd29: c = '{OP_MUL_LO,    M_S2,   D_NONE};
      6'd30: c = '{OP_MUL_HI,    M_S2,   D_NONE};
      6'd31: c = '{OP_STORE,     M_NONE, D_B};
      6'd32: c = '{OP_MUL_LO,    M_CL,   D_NONE};
      6'd33: c = '{OP_MUL_HI,    M_CL,   D_NONE};
      6'd34: c = '{OP_STORE,     M_NONE, D_C};
      6'd35: c = '{OP_MUL_LO,    M_CB,   D_NONE};
      6'd36: c = '{OP_MUL_HI,    M_CB,   D_NONE};
      6'd37: c = '{OP_STORE,     M_NONE, D_H};
      6'd38: c = '{OP_SQRT_H,    M_NONE, D_NONE};
      6'd39: c = '{OP_SQRT,      M_NONE, D_NONE};
      6'd40: c = '{OP_STORE,     M_NONE, D_Q};
      6'd41: c = '{OP_MUL_LO,    M_QQ,   D_NONE};
      6'd42: c = '{OP_MUL_HI,    M_QQ,   D_NONE};
      6'd43: c = '{OP_SQRT_R,    M_NONE, D_NONE};
      6'd44: c = '{OP_SQRT,      M_NONE, D_NONE};
      6'd45: c = '{OP_STORE,     M_NONE, D_R};
      6'd46: c = '{OP_VEC_RANGE, M_NONE, D_NONE};
      6'd47: c = '{OP_CORDIC,    M_NONE, D_NONE};
      6'd48: c = '{OP_STORE,     M_NONE, D_ANG};
      6'd49: c = '{OP_MUL_LO,    M_RNG,  D_NONE};
      6'd50: c = '{OP_MUL_HI,    M_RNG,  D_NONE};
      6'd51: c = '{OP_STORE,     M_NONE, D_RNG};
      default: c = '{OP_DONE,    M_NONE, D_NONE};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/ghrb_ctrl.sv @@
// Sequencer: steps the datapath through the program for one fix.
module ghrb_ctrl import ghrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  dp_cmd_t         prog;
  logic            adv;

  assign prog = ucode(pc_q);

  always_comb begin
    case (prog.op)
      OP_CORDIC: adv = sts_i.cordic_last;
      OP_SQRT:   adv = sts_i.sqrt_last;
      OP_DONE:   adv = sts_i.out_free;
      default:   adv = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_RUN;
          pc_d    = '0;
        end
      end
      CS_RUN: begin
        if (adv) begin
          if (prog.op == OP_DONE) begin
            state_d = CS_IDLE;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '{OP_NOP, M_NONE, D_NONE};
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = '{OP_CAPTURE, M_NONE, D_NONE};
      end
      CS_RUN:  cmd_o = prog;
      default: cmd_o = '{OP_NOP, M_NONE, D_NONE};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

@@ rtl/core/ghrb_datapath.sv @@
// Datapath: CORDIC unit, split multiplier, bit-serial square root and result register.
module ghrb_datapath import ghrb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [30:0] fix_latitude_i,
  input  logic signed [31:0] fix_longitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] travel_heading_o,
  output logic               heading_valid_o,
  output logic [34:0]        range_to_target_o,
  output logic signed [15:0] bearing_error_o
);

  logic signed [30:0] tgt_lat_q, fix_lat_q, last_lat_q;
  logic signed [31:0] tgt_lon_q, fix_lon_q, last_lon_q;
  logic               have_q;

  logic signed [52:0] cx_q, cy_q, dx, dy, vx_w, vy_w;
  logic [31:0]        cz_q, at, ang_rot;
  logic [CNT_W-1:0]   cnt_q;
  logic               vec_q, zero_q, flip_q;
  logic signed [32:0] vx, vy;

  logic signed [67:0] acc_q, rnd_half, rnd_full, acc_sh, rng_sh;
  logic signed [33:0] ma, mb;
  logic signed [51:0] p_lo;
  logic signed [50:0] p_hi;

  logic [31:0]        head_q, goal_q, ang_q, hsum, bsum;
  logic signed [33:0] s1_q, s2_q, cl1_q, cl2_q, a_q, b_q, c_q;
  logic signed [35:0] h_sum;
  logic [30:0]        h_q, q_q, r_q;
  logic [63:0]        sv_q, sr_q, sb_q, s_try;

  logic               out_valid_q, out_hv_q;
  logic [15:0]        out_head_q, out_bear_q;
  logic [34:0]        out_rng_q, rng_val, rng_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign sts_o = '{cordic_last: (cnt_q == CNT_W'(STEPS - 1)),
                   sqrt_last:   sb_q[0],
                   out_free:    out_free};

  // vectoring operands
  always_comb begin
    case (cmd_i.op)
      OP_VEC_HEAD: begin
        vy = 33'(fix_lon_q) - 33'(last_lon_q);
        vx = 33'(fix_lat_q) - 33'(last_lat_q);
      end
      OP_VEC_GOAL: begin
        vy = 33'(tgt_lon_q) - 33'(fix_lon_q);
        vx = 33'(tgt_lat_q) - 33'(fix_lat_q);
      end
      default: begin
        vy = $signed({2'b00, q_q});
        vx = $signed({2'b00, r_q});
      end
    endcase
  end
  assign vx_w = {{4{vx[32]}}, vx, 16'h0000};
  assign vy_w = {{4{vy[32]}}, vy, 16'h0000};

  assign dx = cy_q >>> cnt_q;
  assign dy = cx_q >>> cnt_q;
  assign at = atan_tab(6'(cnt_q));

  // multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.msel)
      M_DLAT: begin ma = 34'(fix_lat_q) - 34'(tgt_lat_q); mb = DEG_TO_BAM; end
      M_DLON: begin ma = 34'(fix_lon_q) - 34'(tgt_lon_q); mb = DEG_TO_BAM; end
      M_LAT:  begin ma = 34'(fix_lat_q);                  mb = DEG_TO_BAM; end
      M_TLAT: begin ma = 34'(tgt_lat_q);                  mb = DEG_TO_BAM; end
      M_S1:   begin ma = s1_q;  mb = s1_q;  end
      M_S2:   begin ma = s2_q;  mb = s2_q;  end
      M_CL:   begin ma = cl1_q; mb = cl2_q; end
      M_CB:   begin ma = c_q;   mb = b_q;   end
      M_QQ:   begin ma = $signed({3'b000, q_q}); mb = $signed({3'b000, q_q}); end
      M_RNG:  begin ma = $signed({2'b00, ang_q}); mb = RANGE_MUL; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign p_lo = $signed({1'b0, ma[16:0]}) * mb;
  assign p_hi = $signed(ma[33:17]) * mb;

  assign rnd_half = acc_q + 68'sd268435456;
  assign rnd_full = acc_q + 68'sd134217728;
  assign ang_rot  = (cmd_i.op == OP_ROT_HALF) ? rnd_half[60:29] : rnd_full[59:28];

  assign acc_sh = acc_q >>> 30;
  assign h_sum  = 36'(a_q) + 36'($signed(acc_sh[33:0]));
  assign rng_sh = (acc_q + 68'sd8388608) >>> 24;
  assign rng_val = (rng_sh > 68'(RANGE_MAX)) ? RANGE_MAX : rng_sh[34:0];
  assign s_try  = sr_q + sb_q;

  assign hsum = head_q + 32'h0000_8000;
  assign bsum = goal_q - head_q + 32'h0000_8000;

  // configuration and held fix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lat_q  <= TGT_LAT_RST;
      tgt_lon_q  <= TGT_LON_RST;
      last_lat_q <= '0;
      last_lon_q <= '0;
      have_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_TARGET_LAT) tgt_lat_q <= cfg_data_i[30:0];
      if (cfg_we_i && cfg_idx_i == REG_TARGET_LON) tgt_lon_q <= cfg_data_i;
      if (cmd_i.op == OP_DONE && out_free) begin
        last_lat_q <= fix_lat_q;
        last_lon_q <= fix_lon_q;
        have_q     <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        fix_lat_q <= fix_latitude_i;
        fix_lon_q <= fix_longitude_i;
      end
      OP_VEC_HEAD, OP_VEC_GOAL, OP_VEC_RANGE: begin
        vec_q  <= 1'b1;
        zero_q <= (vx == '0) && (vy == '0);
        cnt_q  <= '0;
        if (vx[32]) begin
          cx_q <= -vx_w;
          cy_q <= -vy_w;
          cz_q <= 32'h8000_0000;
        end else begin
          cx_q <= vx_w;
          cy_q <= vy_w;
          cz_q <= 32'h0000_0000;
        end
      end
      OP_ROT_HALF, OP_ROT_FULL: begin
        vec_q <= 1'b0;
        cnt_q <= '0;
        cx_q  <= CORDIC_GAIN_Q30;
        cy_q  <= '0;
        if (((ang_rot + 32'h4000_0000) >> 31) != 32'd0) begin
          cz_q   <= ang_rot + 32'h8000_0000;
          flip_q <= 1'b1;
        end else begin
          cz_q   <= ang_rot;
          flip_q <= 1'b0;
        end
      end
      OP_CORDIC: begin
        cnt_q <= cnt_q + 1'b1;
        if (vec_q ? !cy_q[52] : cz_q[31]) begin
          cx_q <= vec_q ? cx_q + dx : cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end
      end
      OP_MUL_LO: acc_q <= 68'(p_lo);
      OP_MUL_HI: acc_q <= acc_q + (68'(p_hi) <<< 17);
      OP_SQRT_H: begin
        sv_q <= {3'b000, h_q, 30'h0};
        sr_q <= '0;
        sb_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_R: begin
        sv_q <= 64'h1000_0000_0000_0000 - acc_q[63:0];
        sr_q <= '0;
        sb_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sv_q >= s_try) begin
          sv_q <= sv_q - s_try;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_STORE: begin
        case (cmd_i.dst)
          D_HEAD: head_q <= (have_q && !zero_q) ? cz_q : 32'h0;
          D_GOAL: goal_q <= zero_q ? 32'h0 : cz_q;
          D_S1:   s1_q   <= flip_q ? -cy_q[33:0] : cy_q[33:0];
          D_S2:   s2_q   <= flip_q ? -cy_q[33:0] : cy_q[33:0];
          D_CL1:  cl1_q  <= flip_q ? -cx_q[33:0] : cx_q[33:0];
          D_CL2:  cl2_q  <= flip_q ? -cx_q[33:0] : cx_q[33:0];
          D_A:    a_q    <= acc_sh[33:0];
          D_B:    b_q    <= acc_sh[33:0];
          D_C:    c_q    <= acc_sh[33:0];
          D_H: begin
            if (h_sum < 0)                     h_q <= '0;
            else if (h_sum > 36'sd1073741824) h_q <= 31'h4000_0000;
            else                               h_q <= h_sum[30:0];
          end
          D_Q:    q_q    <= sr_q[30:0];
          D_R:    r_q    <= sr_q[30:0];
          D_ANG:  ang_q  <= zero_q ? 32'h0 : cz_q;
          D_RNG:  rng_q  <= rng_val;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (cmd_i.op == OP_DONE && out_free) begin
      out_head_q <= have_q ? hsum[31:16] : 16'h0000;
      out_bear_q <= bsum[31:16];
      out_hv_q   <= have_q;
      out_rng_q  <= rng_q;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign travel_heading_o  = out_head_q;
  assign heading_valid_o   = out_hv_q;
  assign range_to_target_o = out_rng_q;
  assign bearing_error_o   = out_bear_q;

endmodule

@@ rtl/core/gps_heading_range_bearing.sv @@
// Top level of the GPS navigator: heading, haversine range and bearing error per fix.
//
// Input channel (in_valid_i/in_ready_o) takes one fix per beat: latitude and
// longitude in 1e-7 degree. Output channel (out_valid_o/out_ready_i) returns one
// beat per fix: travel heading and bearing error as 16-bit binary angles, the
// heading valid flag and the range to the goal in millimetres.
// The goal position sits in two registers written over cfg_we_i/cfg_idx_i/
// cfg_data_i (index 0 latitude, index 1 longitude); write them while idle.
// A sequencer drives one shared CORDIC unit, a two-pass 17 x 34 multiplier and
// a bit-serial square root. From the accepting edge to out_valid_o each fix
// runs the CORDIC unit seven times and the square root twice, between the
// multiplier, setup and store steps of the program.
// One fix is in work at a time; in_ready_o is high only while the sequencer is
// idle, so a new fix is taken only once the last one has finished the program.
// The result register frees the sequencer: the next fix is taken while a
// result still waits; if the receiver stalls, the sequencer holds at its last
// step until the register is taken.
// Reset clears the held fix (first result flags no heading) and loads the
// default goal.
module gps_heading_range_bearing import ghrb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] fix_latitude_i,
  input  logic signed [31:0] fix_longitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] travel_heading_o,
  output logic               heading_valid_o,
  output logic [34:0]        range_to_target_o,
  output logic signed [15:0] bearing_error_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  ghrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, held fix, goal registers and result register
  ghrb_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fix_latitude_i    (fix_latitude_i),
    .fix_longitude_i   (fix_longitude_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .travel_heading_o  (travel_heading_o),
    .heading_valid_o   (heading_valid_o),
    .range_to_target_o (range_to_target_o),
    .bearing_error_o   (bearing_error_o)
  );

endmodule

@@ rtl/core/ghrb_checker.sv @@
// Port-level checks of the navigator, bound to the top level.
module ghrb_checker import ghrb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] travel_heading_o,
  input logic               heading_valid_o,
  input logic [34:0]        range_to_target_o,
  input logic signed [15:0] bearing_error_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_to_target_o)
      && $stable(travel_heading_o) && $stable(bearing_error_o))
    else $error("stalled result changed");

  // one fix in work: no second beat right after an accepted one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> range_to_target_o <= RANGE_MAX)
    else $error("range above saturation");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !heading_valid_o |-> travel_heading_o == 16'sd0)
    else $error("heading given without previous fix");

endmodule

bind gps_heading_range_bearing ghrb_checker u_ghrb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .travel_heading_o  (travel_heading_o),
  .heading_valid_o   (heading_valid_o),
  .range_to_target_o (range_to_target_o),
  .bearing_error_o   (bearing_error_o)
);

@@ test/tb_gps_heading_range_bearing.sv @@
// Self-checking testbench of the GPS navigator: heading, haversine range and bearing error.
//
// Fixes are queued by the stimulus block and presented by a clocked driver at the
// falling edge. Goal writes and drain points are queued the same way. A monitor at
// the rising edge predicts each accepted fix with its own bit-exact model and
// compares each result beat with the oldest expectation.
module tb_gps_heading_range_bearing;
  import ghrb_pkg::*;

  typedef enum logic [1:0] {K_FIX, K_CFG, K_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic [31:0] a;
    logic [31:0] b;
  } job_t;

  typedef struct {
    logic [15:0] heading;
    logic        head_ok;
    logic [34:0] range_mm;
    logic [15:0] brg_err;
  } nav_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [30:0] fix_latitude_i = '0;
  logic signed [31:0] fix_longitude_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] travel_heading_o;
  logic               heading_valid_o;
  logic [34:0]        range_to_target_o;
  logic signed [15:0] bearing_error_o;

  gps_heading_range_bearing u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .fix_latitude_i, .fix_longitude_i,
    .out_valid_o, .out_ready_i, .travel_heading_o, .heading_valid_o,
    .range_to_target_o, .bearing_error_o
  );

  always #5 clk_i = ~clk_i;

  // Arctangent of 2^-i as a 32-bit binary angle.
  localparam logic [31:0] ATAN_LUT [0:39] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1,
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // Navigator state mirrored by the predictor.
  longint aim_lat, aim_lon, prev_lat, prev_lon;
  bit     prev_ok;

  job_t        pending_jobs[$];
  nav_result_t expected_results[$];
  int          mismatches = 0;
  bit          in_fire, out_fire;
  bit          calm = 1'b0;
  int          send_gap = 0, recv_gap = 0, quiet_cycles = 0;

  function automatic logic [31:0] deg_to_angle(longint units, int sh);
    longint p;
    p = units * 320255973 + (longint'(1) <<< (sh - 1));
    p = p >>> sh;
    return p[31:0];
  endfunction

  task automatic rotate(input logic [31:0] z_in, output longint c, output longint s);
    logic [31:0] z, t;
    longint      x, y, dx, dy;
    bit          flip;
    z = z_in;
    x = 652032874;
    y = 0;
    t = z + 32'h4000_0000;
    flip = t[31];
    if (flip) z = z + 32'h8000_0000;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[31]) begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end else begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] vec_angle(longint y_in, longint x_in);
    logic [31:0] z;
    longint      x, y, dx, dy;
    z = '0;
    if (x_in == 0 && y_in == 0) return '0;
    x = x_in * 65536;
    y = y_in * 65536;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic great_circle_mm(input longint lat, input longint lon,
                                 output logic [34:0] mm);
    longint          c1, s1, c2, s2, cl1, cl2, junk, a, b, c, h;
    longint unsigned q, r, d;
    logic [31:0]     ang;
    rotate(deg_to_angle(lat - aim_lat, 29), c1, s1);
    rotate(deg_to_angle(lon - aim_lon, 29), c2, s2);
    rotate(deg_to_angle(lat, 28), cl1, junk);
    rotate(deg_to_angle(aim_lat, 28), cl2, junk);
    a = (s1 * s1) >>> 30;
    b = (s2 * s2) >>> 30;
    c = (cl1 * cl2) >>> 30;
    h = a + ((c * b) >>> 30);
    // clamp the haversine term to [0, 1]
    if (h < 0) h = 0;
    if (h > (longint'(1) <<< 30)) h = longint'(1) <<< 30;
    q = int_sqrt(64'(h) << 30);
    r = int_sqrt((64'd1 << 60) - q * q);
    ang = vec_angle(longint'(q), longint'(r));
    d = (64'(ang) * 64'd312823969 + (64'd1 << 23)) >> 24;
    if (d > 64'd20020706000) d = 64'd20020706000;
    mm = d[34:0];
  endtask

  task automatic predict_fix(input logic signed [30:0] lat_f,
                             input logic signed [31:0] lon_f);
    nav_result_t r;
    longint      lat, lon;
    logic [31:0] hd, goal, t;
    lat = lat_f;
    lon = lon_f;
    hd = '0;
    if (prev_ok) hd = vec_angle(lon - prev_lon, lat - prev_lat);
    goal = vec_angle(aim_lon - lon, aim_lat - lat);
    t = hd + 32'h8000;
    r.heading = t[31:16];
    r.head_ok = prev_ok;
    great_circle_mm(lat, lon, r.range_mm);
    t = goal - hd + 32'h8000;
    r.brg_err = t[31:16];
    expected_results.push_back(r);
    prev_lat = lat;
    prev_lon = lon;
    prev_ok = 1'b1;
  endtask

  // Monitor: note handshakes, predict accepted fixes, check result beats.
  always @(posedge clk_i) begin
    nav_result_t e;
    in_fire = in_valid_i && in_ready_o;
    out_fire = out_valid_o && out_ready_i;
    if (in_fire) predict_fix(fix_latitude_i, fix_longitude_i);
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        e = expected_results.pop_front();
        if (travel_heading_o !== e.heading || heading_valid_o !== e.head_ok ||
            range_to_target_o !== e.range_mm || bearing_error_o !== e.brg_err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hd=%0d ok=%0d rng=%0d err=%0d got hd=%0d ok=%0d rng=%0d err=%0d",
                     $signed(e.heading), e.head_ok, e.range_mm, $signed(e.brg_err),
                     travel_heading_o, heading_valid_o, range_to_target_o, bearing_error_o);
        end
      end
    end
    quiet_cycles = (expected_results.size() == 0) ? quiet_cycles + 1 : 0;
  end

  // Driver: present jobs at the falling edge; hold a fix until its beat is taken.
  always @(negedge clk_i) begin
    job_t j;
    bit   nv, nwe;
    if (rst_ni) begin
      // receiver side: draw a stall for each result, counted while it waits
      if (out_fire) begin
        recv_gap = calm ? 0 : $urandom_range(0, 16);
        out_ready_i <= (recv_gap == 0);
      end else if (out_valid_o && !out_ready_i) begin
        if (recv_gap > 0) recv_gap--;
        out_ready_i <= (recv_gap == 0);
      end
      if (!(in_valid_i && !in_fire)) begin
        nv = 1'b0;
        nwe = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_jobs.size() != 0) begin
          j = pending_jobs[0];
          case (j.kind)
            K_FIX: begin
              fix_latitude_i <= j.a[30:0];
              fix_longitude_i <= j.b;
              nv = 1'b1;
              void'(pending_jobs.pop_front());
              send_gap = calm ? 0 : $urandom_range(0, 16);
            end
            K_CFG: begin
              // write the goal only once the block has gone quiet
              if (quiet_cycles > 16) begin
                nwe = 1'b1;
                cfg_idx_i <= j.a[0];
                cfg_data_i <= j.b;
                if (j.a[0] == REG_TARGET_LAT) aim_lat = longint'($signed(j.b[30:0]));
                else aim_lon = longint'($signed(j.b));
                void'(pending_jobs.pop_front());
              end
            end
            default: begin
              // hold off until every result is back
              if (expected_results.size() == 0) void'(pending_jobs.pop_front());
            end
          endcase
        end
        in_valid_i <= nv;
        cfg_we_i <= nwe;
      end else begin
        cfg_we_i <= 1'b0;
      end
    end
  end

  task automatic add_fix(input logic [31:0] lat, input logic [31:0] lon);
    pending_jobs.push_back('{K_FIX, lat, lon});
  endtask

  task automatic add_goal(input logic [31:0] lat, input logic [31:0] lon);
    pending_jobs.push_back('{K_CFG, 32'(REG_TARGET_LAT), lat});
    pending_jobs.push_back('{K_CFG, 32'(REG_TARGET_LON), lon});
  endtask

  task automatic add_random_phase(input int n);
    int lat, lon;
    lat = $urandom_range(0, 1800000000) - 900000000;
    lon = $urandom_range(0, 2000000000) - 1000000000;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: add_fix($urandom, $urandom);
        1, 2: begin
          lat = $urandom_range(0, 1800000000) - 900000000;
          lon = int'($urandom_range(0, 3600000000)) - 1800000000;
          add_fix(lat, lon);
        end
        3: add_fix(lat, lon);
        default: begin
          // walk near the last fix
          lat += $urandom_range(0, 4000) - 2000;
          lon += $urandom_range(0, 4000) - 2000;
          add_fix(lat, lon);
        end
      endcase
      if (k == n / 2) pending_jobs.push_back('{K_DRAIN, '0, '0});
    end
  endtask

  initial begin
    aim_lat = 459448010;
    aim_lon = -666422750;
    prev_lat = 0;
    prev_lon = 0;
    prev_ok = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first fix, no movement, fix on the goal, field extremes
    calm = 1'b1;
    add_fix(0, 0);
    add_fix(0, 0);
    add_fix(459448010, -666422750);
    add_fix(900000000, 1800000000);
    add_fix(-900000000, -1800000000);
    add_fix(32'h3FFF_FFFF, 32'h7FFF_FFFF);
    add_fix(32'h4000_0000, 32'h8000_0000);
    add_fix(900000000, -1800000000);
    add_fix(-900000000, 1800000000);
    add_fix(-900000000, 1800000000);
    add_goal(900000000, 1800000000);
    add_fix(-900000000, -1800000000);
    add_fix(900000000, 1800000000);
    add_goal(-900000000, -1800000000);
    add_fix(900000000, 1800000000);
    add_fix(0, 0);
    add_goal(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_fix(32'h4000_0000, 32'h8000_0000);
    add_fix(32'h3FFF_FFFF, 0);

    for (int p = 0; p < 4; p++) begin
      if (p == 1) add_goal(32'h4000_0000, 32'h8000_0000);
      else add_goal($urandom_range(0, 1800000000) - 900000000,
                    int'($urandom_range(0, 3600000000)) - 1800000000);
      add_random_phase(100);
    end

    wait (pending_jobs.size() == 0);
    calm = 1'b0;
    wait (pending_jobs.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_gps_heading_range_bearing passed");
    end else begin
      $display("tb_gps_heading_range_bearing failed");
    end
    $finish;
  end

  // Toggle calm stretches so some phases run with no idling at all.
  always @(posedge clk_i) begin
    if (rst_ni && in_fire && $urandom_range(0, 39) == 0) calm = ~calm;
  end

  initial begin
    #30_000_000;
    $display("tb_gps_heading_range_bearing failed");
    $finish;
  end

endmodule
